>>> rtl/core/time_of_day_palette_tint_assert.svh
// Assertion macros for the palette tint block.
// Each check is clocked on clk_i. TOD_ASSERT is disabled while rst_ni is low.
// TOD_ASSERT_RST is also checked during reset.
`ifndef TIME_OF_DAY_PALETTE_TINT_ASSERT_SVH
`define TIME_OF_DAY_PALETTE_TINT_ASSERT_SVH

`ifndef SYNTHESIS
`define TOD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tint assertion failed");
`define TOD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("tint reset assertion failed");
`else
`define TOD_ASSERT(lbl, prop)
`define TOD_ASSERT_RST(lbl, prop)
`endif

`endif

>>> rtl/core/tod_tint_pkg.sv
`timescale 1ns / 1ps
package tod_tint_pkg;

  localparam int PaletteEntries = 512;
  localparam int IndexWidth     = 9;
  localparam int ColourWidth    = 15;
  localparam int CfgIdxWidth    = 3;
  localparam int CfgDataWidth   = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgHourOfDay        = 3'd0,
    CfgMinuteOfHour     = 3'd1,
    CfgInBattle         = 3'd2,
    CfgMapExempt        = 3'd3,
    CfgFadeActive       = 3'd4,
    CfgWorldPaletteMask = 3'd5,
    CfgBattlePaletteMask = 3'd6,
    CfgUnused           = 3'd7
  } cfg_idx_e;

  localparam logic [31:0] WorldMaskReset  = 32'hFFFF_1FFF;
  localparam logic [31:0] BattleMaskReset = 32'h0000_FFDC;

  localparam logic [15:0] TagExc0 = 16'hD6FF;
  localparam logic [15:0] TagExc1 = 16'hD704;
  localparam logic [15:0] TagExc2 = 16'hD710;
  localparam logic [15:0] TagExc3 = 16'hD712;

  localparam logic [4:0] HourDawn      = 5'd7;
  localparam logic [4:0] HourDay       = 5'd8;
  localparam logic [4:0] HourSunset    = 5'd19;
  localparam logic [4:0] HourNightfall = 5'd20;
  localparam logic [4:0] HourNight     = 5'd21;
  localparam logic [4:0] HalfMinuteMax = 5'd29;

  typedef struct packed {
    logic [IndexWidth-1:0]  colour_index;
    logic [ColourWidth-1:0] faded_colour;
    logic                   unfaded_is_black;
    logic [15:0]            sprite_tag;
  } tint_in_t;

  typedef struct packed {
    logic [ColourWidth-1:0] out_colour;
    logic                   rewrite_unfaded;
    logic [ColourWidth-1:0] light_colour;
  } tint_out_t;

  typedef struct packed {
    logic                   hit;
    logic [ColourWidth-1:0] colour;
  } light_hit_t;

  function automatic logic [14:0] rgb555(input int r, input int g, input int b);
    rgb555 = {5'(b), 5'(g), 5'(r)};
  endfunction

  localparam logic [14:0] NightFilter = rgb555(14, 14, 6);
  localparam logic [14:0] LightHigh   = rgb555(30, 30, 5);
  localparam logic [14:0] LightMid    = rgb555(26, 25, 4);
  localparam logic [14:0] LightLow    = rgb555(22, 21, 3);

  function automatic logic [14:0] midnight_rom(input logic [2:0] i);
    logic [14:0] c;
    unique case (i)
      3'd0: c = rgb555(14, 14, 6);
      3'd1: c = rgb555(14, 14, 7);
      3'd2: c = rgb555(14, 14, 8);
      3'd3: c = rgb555(15, 15, 8);
      3'd4: c = rgb555(15, 15, 9);
      3'd5: c = rgb555(15, 15, 9);
      3'd6: c = rgb555(16, 16, 9);
      default: c = rgb555(16, 16, 10);
    endcase
    return c;
  endfunction

  function automatic logic [14:0] dawn_rom(input logic [4:0] i);
    logic [14:0] c;
    unique case (i)
      5'd0:  c = rgb555(15, 15, 10);
      5'd1:  c = rgb555(15, 15, 10);
      5'd2:  c = rgb555(14, 14, 10);
      5'd3:  c = rgb555(13, 13, 10);
      5'd4:  c = rgb555(12, 12, 10);
      5'd5:  c = rgb555(11, 11, 10);
      5'd6:  c = rgb555(10, 10, 10);
      5'd7:  c = rgb555(9, 9, 10);
      5'd8:  c = rgb555(8, 8, 10);
      5'd9:  c = rgb555(8, 8, 11);
      5'd10: c = rgb555(7, 7, 11);
      5'd11: c = rgb555(6, 6, 11);
      5'd12: c = rgb555(5, 5, 11);
      5'd13: c = rgb555(4, 4, 11);
      5'd14: c = rgb555(3, 3, 11);
      5'd15: c = rgb555(2, 2, 11);
      5'd16: c = rgb555(1, 1, 11);
      5'd17: c = rgb555(0, 0, 11);
      5'd18: c = rgb555(0, 0, 10);
      5'd19: c = rgb555(0, 0, 9);
      5'd20: c = rgb555(0, 0, 8);
      5'd21: c = rgb555(0, 0, 7);
      5'd22: c = rgb555(0, 0, 6);
      5'd23: c = rgb555(0, 0, 5);
      5'd24: c = rgb555(0, 0, 4);
      5'd25: c = rgb555(0, 0, 3);
      5'd26: c = rgb555(0, 0, 2);
      5'd27: c = rgb555(0, 0, 1);
      default: c = rgb555(0, 0, 0);
    endcase
    return c;
  endfunction

  function automatic logic [14:0] sunset_rom(input logic [4:0] i);
    logic [14:0] c;
    unique case (i)
      5'd0:  c = rgb555(0, 0, 1);
      5'd1:  c = rgb555(0, 1, 1);
      5'd2:  c = rgb555(0, 1, 2);
      5'd3:  c = rgb555(0, 1, 3);
      5'd4:  c = rgb555(0, 2, 3);
      5'd5:  c = rgb555(0, 2, 4);
      5'd6:  c = rgb555(0, 2, 5);
      5'd7:  c = rgb555(0, 3, 5);
      5'd8:  c = rgb555(0, 3, 6);
      5'd9:  c = rgb555(0, 3, 7);
      5'd10: c = rgb555(0, 4, 7);
      5'd11: c = rgb555(0, 4, 8);
      5'd12: c = rgb555(0, 4, 9);
      5'd13: c = rgb555(0, 5, 9);
      5'd14: c = rgb555(0, 5, 10);
      5'd15: c = rgb555(0, 5, 11);
      5'd16: c = rgb555(0, 6, 11);
      5'd17: c = rgb555(0, 6, 12);
      5'd18: c = rgb555(0, 6, 13);
      5'd19: c = rgb555(0, 7, 13);
      5'd20: c = rgb555(0, 7, 14);
      5'd21: c = rgb555(0, 7, 14);
      5'd22: c = rgb555(0, 8, 14);
      5'd23: c = rgb555(0, 9, 14);
      5'd24: c = rgb555(0, 10, 14);
      5'd25: c = rgb555(0, 11, 14);
      5'd26: c = rgb555(0, 12, 14);
      5'd27: c = rgb555(0, 13, 14);
      default: c = rgb555(0, 14, 14);
    endcase
    return c;
  endfunction

  function automatic logic [14:0] nightfall_rom(input logic [4:0] i);
    logic [14:0] c;
    unique case (i)
      5'd0:  c = rgb555(0, 14, 14);
      5'd1:  c = rgb555(0, 14, 14);
      5'd2:  c = rgb555(0, 14, 13);
      5'd3:  c = rgb555(0, 14, 12);
      5'd4:  c = rgb555(0, 14, 11);
      5'd5:  c = rgb555(0, 14, 10);
      5'd6:  c = rgb555(1, 14, 10);
      5'd7:  c = rgb555(1, 14, 9);
      5'd8:  c = rgb555(0, 14, 8);
      5'd9:  c = rgb555(1, 14, 7);
      5'd10: c = rgb555(1, 14, 6);
      5'd11: c = rgb555(2, 14, 6);
      5'd12: c = rgb555(2, 14, 5);
      5'd13: c = rgb555(2, 14, 4);
      5'd14: c = rgb555(2, 14, 3);
      5'd15: c = rgb555(2, 14, 2);
      5'd16: c = rgb555(2, 14, 2);
      5'd17: c = rgb555(3, 14, 3);
      5'd18: c = rgb555(4, 14, 4);
      5'd19: c = rgb555(5, 14, 5);
      5'd20: c = rgb555(6, 14, 6);
      5'd21: c = rgb555(7, 14, 6);
      5'd22: c = rgb555(8, 14, 6);
      5'd23: c = rgb555(9, 14, 6);
      5'd24: c = rgb555(10, 14, 6);
      5'd25: c = rgb555(11, 14, 6);
      5'd26: c = rgb555(12, 14, 6);
      5'd27: c = rgb555(13, 14, 6);
      default: c = rgb555(14, 14, 6);
    endcase
    return c;
  endfunction

  // Fixed light slots: palette 0 colours 1..3, palette 1 colours 1..2,
  // palette 6 colours 1..3.
  function automatic light_hit_t light_lookup(input logic [IndexWidth-1:0] idx);
    light_hit_t h;
    h.hit    = 1'b1;
    unique case (idx)
      9'd1, 9'd17, 9'd97: h.colour = LightHigh;
      9'd2, 9'd18, 9'd98: h.colour = LightMid;
      9'd3, 9'd99:        h.colour = LightLow;
      default: begin
        h.hit    = 1'b0;
        h.colour = '0;
      end
    endcase
    return h;
  endfunction

  function automatic logic [4:0] scale_chan(input logic [4:0] c, input logic [4:0] f);
    logic [9:0] p;
    p = 10'(c) * 10'(5'd31 - f);
    return p[9:5];
  endfunction

endpackage

>>> rtl/core/time_of_day_palette_tint.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        sink       in_valid_i/in_stall_o   tint_in_t (index, colour, black, tag)
// out       source     out_valid_o/out_stall_i tint_out_t (colour, rewrite, light)
// cfg       sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while out_stall_i does not hold the output; the path has two
// registers (input register, result register) with the tint logic between them.
// Reset clears the configuration to its defaults and empties both stages.
// A stalled result holds in the output register while the input register
// takes one more transaction; in_stall_o rises only when both are full.
module time_of_day_palette_tint
  import tod_tint_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tint_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output tint_out_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  `include "time_of_day_palette_tint_assert.svh"

  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic        in_battle_q;
  logic        map_exempt_q;
  logic        fade_active_q;
  logic [31:0] world_mask_q;
  logic [31:0] battle_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q        <= '0;
      minute_q      <= '0;
      in_battle_q   <= 1'b0;
      map_exempt_q  <= 1'b0;
      fade_active_q <= 1'b0;
      world_mask_q  <= WorldMaskReset;
      battle_mask_q <= BattleMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHourOfDay:         hour_q        <= cfg_wdata_i[4:0];
        CfgMinuteOfHour:      minute_q      <= cfg_wdata_i[5:0];
        CfgInBattle:          in_battle_q   <= cfg_wdata_i[0];
        CfgMapExempt:         map_exempt_q  <= cfg_wdata_i[0];
        CfgFadeActive:        fade_active_q <= cfg_wdata_i[0];
        CfgWorldPaletteMask:  world_mask_q  <= cfg_wdata_i;
        CfgBattlePaletteMask: battle_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic      s1_valid_q, out_valid_q;
  tint_in_t  s1_data_q;
  tint_out_t out_data_q, out_data_d;
  logic      s2_en, s1_en;

  assign s2_en      = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) s1_data_q <= in_data_i;
    if (s2_en && s1_valid_q) out_data_q <= out_data_d;
  end

  // Filter colour depends on configuration only
  logic [4:0]  half_min;
  logic [14:0] filter;

  always_comb begin
    half_min = minute_q[5:1];
    if (half_min > HalfMinuteMax) half_min = HalfMinuteMax;
  end

  always_comb begin
    priority if (hour_q < HourDawn) begin
      filter = (hour_q == '0) ? midnight_rom(minute_q[5:3]) : midnight_rom(3'd7);
    end else if (hour_q < HourDay) begin
      filter = dawn_rom(half_min);
    end else if (hour_q < HourSunset) begin
      filter = '0;
    end else if (hour_q < HourNightfall) begin
      filter = sunset_rom(half_min);
    end else if (hour_q < HourNight) begin
      filter = nightfall_rom(half_min);
    end else begin
      filter = NightFilter;
    end
  end

  // Tint datapath
  logic [4:0]  pal;
  logic [31:0] mask;
  logic        tag_exc;
  logic        tint_en;
  logic        lights_on;
  logic        in_range;
  logic [14:0] scaled;
  light_hit_t  light;

  assign pal      = s1_data_q.colour_index[IndexWidth-1:4];
  assign mask     = in_battle_q ? battle_mask_q : world_mask_q;
  assign tag_exc  = (s1_data_q.sprite_tag == TagExc0) || (s1_data_q.sprite_tag == TagExc1) ||
                    (s1_data_q.sprite_tag == TagExc2) || (s1_data_q.sprite_tag == TagExc3);
  assign tint_en  = mask[pal] && (!pal[4] || !tag_exc);
  assign in_range = {1'b0, s1_data_q.colour_index} < (IndexWidth + 1)'(PaletteEntries);
  assign lights_on = !map_exempt_q && !in_battle_q && (hour_q >= HourNight || hour_q < HourDawn);
  assign light    = light_lookup(s1_data_q.colour_index);

  assign scaled = {scale_chan(s1_data_q.faded_colour[14:10], filter[14:10]),
                   scale_chan(s1_data_q.faded_colour[9:5],   filter[9:5]),
                   scale_chan(s1_data_q.faded_colour[4:0],   filter[4:0])};

  always_comb begin
    out_data_d.out_colour      = s1_data_q.faded_colour;
    out_data_d.rewrite_unfaded = 1'b0;
    out_data_d.light_colour    = '0;
    if (in_range) begin
      if (tint_en) out_data_d.out_colour = scaled;
      if (lights_on && light.hit) begin
        if (fade_active_q || !s1_data_q.unfaded_is_black) begin
          // pass unfiltered and ask for the unfaded copy to take the light
          out_data_d.out_colour      = s1_data_q.faded_colour;
          out_data_d.rewrite_unfaded = 1'b1;
          out_data_d.light_colour    = light.colour;
        end else begin
          out_data_d.out_colour = light.colour;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TOD_ASSERT(a_rewrite_has_light, out_valid_o |-> (out_data_o.rewrite_unfaded == (out_data_o.light_colour != '0)))
  `TOD_ASSERT(a_stage1_holds, (s1_valid_q && !s2_en) |=> s1_valid_q)
  `TOD_ASSERT(a_stall_only_full, in_stall_o |-> (s1_valid_q && out_valid_q))
  `TOD_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

>>> test/tb_time_of_day_palette_tint.sv
`timescale 1ns / 1ps
module tb_time_of_day_palette_tint;
  import tod_tint_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int Phases    = 12;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  tint_in_t                in_item = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  tint_out_t               out_data;
  logic                    cfg_we = 1'b0;
  cfg_idx_e                cfg_idx = CfgUnused;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  // Shadow of the configuration registers.
  logic [4:0]  hour_cfg        = 5'd0;
  logic [5:0]  minute_cfg      = 6'd0;
  logic        battle_cfg      = 1'b0;
  logic        exempt_cfg      = 1'b0;
  logic        fade_cfg        = 1'b0;
  logic [31:0] world_mask_cfg  = WorldMaskReset;
  logic [31:0] battle_mask_cfg = BattleMaskReset;

  // Filter curves, one array per channel that varies; red and green share one where equal.
  int midnight_rg[8] = '{14, 14, 14, 15, 15, 15, 16, 16};
  int midnight_b[8]  = '{6, 7, 8, 8, 9, 9, 9, 10};
  int dawn_rg[30] = '{15, 15, 14, 13, 12, 11, 10, 9, 8, 8, 7, 6, 5, 4, 3, 2, 1,
                      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  int dawn_b[30]  = '{10, 10, 10, 10, 10, 10, 10, 10, 10, 11, 11, 11, 11, 11, 11,
                      11, 11, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0, 0};
  int sunset_g[30] = '{0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5, 6, 6, 6,
                       7, 7, 7, 8, 9, 10, 11, 12, 13, 14, 14};
  int sunset_b[30] = '{1, 1, 2, 3, 3, 4, 5, 5, 6, 7, 7, 8, 9, 9, 10, 11, 11, 12,
                       13, 13, 14, 14, 14, 14, 14, 14, 14, 14, 14, 14};
  int dusk_r[30] = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 1, 2, 2, 2, 2, 2, 2, 3, 4, 5,
                     6, 7, 8, 9, 10, 11, 12, 13, 14, 14};
  int dusk_b[30] = '{14, 14, 13, 12, 11, 10, 10, 9, 8, 7, 6, 6, 5, 4, 3, 2, 2, 3,
                     4, 5, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6};
  int lamp_slots[8] = '{1, 2, 3, 17, 18, 97, 98, 99};
  logic [15:0] tag_list[4] = '{TagExc0, TagExc1, TagExc2, TagExc3};

  tint_in_t  pending[$];
  tint_out_t tint_expected[$];

  int burst_left = 8;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  int idle_cycles = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_rewrites = 0;
  int n_fail     = 0;

  always #5 clk_i = ~clk_i;

  time_of_day_palette_tint DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic logic [14:0] pack_rgb(input int r, input int g, input int b);
    return {5'(b), 5'(g), 5'(r)};
  endfunction

  function automatic logic [14:0] time_filter();
    int half;
    int step;
    half = int'(minute_cfg) >> 1;
    if (half > 29) half = 29;
    if (hour_cfg < HourDawn) begin
      step = (hour_cfg == 5'd0) ? (int'(minute_cfg) >> 3) : 7;
      return pack_rgb(midnight_rg[step], midnight_rg[step], midnight_b[step]);
    end
    if (hour_cfg < HourDay) return pack_rgb(dawn_rg[half], dawn_rg[half], dawn_b[half]);
    if (hour_cfg < HourSunset) return '0;
    if (hour_cfg < HourNightfall) return pack_rgb(0, sunset_g[half], sunset_b[half]);
    if (hour_cfg < HourNight) return pack_rgb(dusk_r[half], 14, dusk_b[half]);
    return pack_rgb(14, 14, 6);
  endfunction

  function automatic logic [4:0] dim_channel(input logic [4:0] c, input logic [4:0] f);
    return 5'((int'(c) * (31 - int'(f))) >> 5);
  endfunction

  function automatic logic lamp_colour(input logic [8:0] idx, output logic [14:0] lc);
    lc = '0;
    case (idx)
      9'd1, 9'd17, 9'd97: lc = LightHigh;
      9'd2, 9'd18, 9'd98: lc = LightMid;
      9'd3, 9'd99:        lc = LightLow;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic tint_out_t tint_predict(input tint_in_t it);
    tint_out_t   res;
    logic [4:0]  pal;
    logic [31:0] mask;
    logic [14:0] flt;
    logic [14:0] lc;
    logic        exc;
    logic        lights_on;
    pal  = it.colour_index[8:4];
    mask = battle_cfg ? battle_mask_cfg : world_mask_cfg;
    flt  = time_filter();
    exc  = (it.sprite_tag == TagExc0) || (it.sprite_tag == TagExc1) ||
           (it.sprite_tag == TagExc2) || (it.sprite_tag == TagExc3);
    res.out_colour      = it.faded_colour;
    res.rewrite_unfaded = 1'b0;
    res.light_colour    = '0;
    if (mask[pal] && (pal < 5'd16 || !exc)) begin
      res.out_colour = {dim_channel(it.faded_colour[14:10], flt[14:10]),
                        dim_channel(it.faded_colour[9:5], flt[9:5]),
                        dim_channel(it.faded_colour[4:0], flt[4:0])};
    end
    lights_on = !exempt_cfg && !battle_cfg && (hour_cfg >= HourNight || hour_cfg < HourDawn);
    if (lights_on && lamp_colour(it.colour_index, lc)) begin
      if (fade_cfg || !it.unfaded_is_black) begin
        res.out_colour      = it.faded_colour;
        res.rewrite_unfaded = 1'b1;
        res.light_colour    = lc;
      end else begin
        res.out_colour = lc;
      end
    end
    return res;
  endfunction

  // Sender: bursts of random length, random gaps in between.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tint_expected.push_back(tint_predict(in_item));
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= pending.pop_front();
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction, and stall on one of four patterns that is chosen anew at random.
  always @(posedge clk_i or negedge rst_ni) begin
    tint_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (tint_expected.size() == 0) begin
          $error("result with nothing expected: %h", out_data);
          n_fail++;
        end else begin
          want = tint_expected.pop_front();
          if (want.rewrite_unfaded) n_rewrites++;
          if (out_data.out_colour !== want.out_colour) begin
            $error("out_colour: expected %h, got %h", want.out_colour, out_data.out_colour);
            n_fail++;
          end
          if (out_data.rewrite_unfaded !== want.rewrite_unfaded) begin
            $error("rewrite_unfaded: expected %b, got %b", want.rewrite_unfaded,
                   out_data.rewrite_unfaded);
            n_fail++;
          end
          if (out_data.light_colour !== want.light_colour) begin
            $error("light_colour: expected %h, got %h", want.light_colour,
                   out_data.light_colour);
            n_fail++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic add_item(input int idx, input int colour, input bit black, input int tag);
    tint_in_t it;
    it.colour_index     = 9'(idx);
    it.faded_colour     = 15'(colour);
    it.unfaded_is_black = black;
    it.sprite_tag       = 16'(tag);
    pending.push_back(it);
  endtask

  function automatic tint_in_t random_item();
    tint_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.colour_index = 9'(lamp_slots[$urandom_range(0, 7)]);
    end else if (pick < 35) begin
      // Neighbors of the light slots.
      it.colour_index = 9'(16 * $urandom_range(0, 1) + $urandom_range(0, 7));
      if ($urandom_range(0, 1)) it.colour_index = 9'(96 + $urandom_range(0, 7));
    end else if (pick < 60) begin
      it.colour_index = 9'($urandom_range(256, 511));
    end else begin
      it.colour_index = 9'($urandom_range(0, 511));
    end
    pick = $urandom_range(0, 9);
    it.faded_colour = (pick == 0) ? 15'h0000 : (pick == 1) ? 15'h7FFF : 15'($urandom());
    it.unfaded_is_black = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 4) it.sprite_tag = tag_list[$urandom_range(0, 3)];
    else if (pick < 5) it.sprite_tag = 16'($urandom_range(16'hD6FE, 16'hD713));
    else it.sprite_tag = 16'($urandom());
    return it;
  endfunction

  task automatic set_reg(input cfg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgHourOfDay:         hour_cfg        = value[4:0];
      CfgMinuteOfHour:      minute_cfg      = value[5:0];
      CfgInBattle:          battle_cfg      = value[0];
      CfgMapExempt:         exempt_cfg      = value[0];
      CfgFadeActive:        fade_cfg        = value[0];
      CfgWorldPaletteMask:  world_mask_cfg  = value;
      CfgBattlePaletteMask: battle_mask_cfg = value;
      default: ;
    endcase
  endtask

  // Wait until every transaction has been sent and answered, then let the pipe settle.
  task automatic drain();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid || tint_expected.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int hour_plan[Phases];
    int minute_plan[Phases];
    int ph;
    int hr;
    int mn;
    logic [31:0] wm;
    logic [31:0] bm;
    logic bat;
    logic exm;
    logic fad;
    hour_plan   = '{0, 0, 6, 7, 7, 12, 19, 20, 21, 31, 24, -1};
    minute_plan = '{0, 63, 17, 59, 62, 30, 45, 61, 5, 63, 0, -1};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: hour 0, lights on, no fade, palettes 13..15 masked out.
    add_item(0, 16'h0000, 1'b0, 0);
    add_item(0, 16'h7FFF, 1'b1, 16'hFFFF);
    for (int i = 0; i < 8; i++) add_item(lamp_slots[i], 16'h7FFF, 1'b1, 0);
    add_item(1, 16'h1234, 1'b0, 0);
    add_item(99, 16'h7FFF, 1'b0, 0);
    add_item(511, 16'h7FFF, 1'b0, 16'hFFFF);
    for (int i = 0; i < 4; i++) add_item(256 + 16 * i, 16'h7FFF, 1'b0, tag_list[i]);
    add_item(256, 16'h7FFF, 1'b1, 16'hD700);
    add_item(20, 16'h7FFF, 1'b0, TagExc1);
    add_item(13 * 16 + 5, 16'h5555, 1'b0, 0);
    add_item(15 * 16 + 15, 16'h2AAA, 1'b1, 0);
    add_item(4, 16'h7FFF, 1'b1, 0);
    add_item(16'h1F0, 16'h7FFF, 1'b1, TagExc0);
    drain();

    for (ph = 0; ph < Phases; ph++) begin
      hr  = (hour_plan[ph] < 0) ? $urandom_range(0, 31) : hour_plan[ph];
      mn  = (minute_plan[ph] < 0) ? $urandom_range(0, 63) : minute_plan[ph];
      bat = (ph % 4 == 3);
      exm = (ph % 5 == 4);
      fad = ph[0];
      wm  = (ph == 2) ? 32'hFFFF_FFFF : (ph == 3 || ph == 6) ? 32'h0 : $urandom();
      bm  = (ph == 3) ? 32'hFFFF_FFFF : (ph == 2 || ph == 7) ? 32'h0 : $urandom();
      if (ph == Phases - 1) begin
        bat = 1'($urandom_range(0, 1));
        exm = 1'($urandom_range(0, 1));
        fad = 1'($urandom_range(0, 1));
      end
      // Put junk above the register width of the narrow registers.
      set_reg(CfgHourOfDay, ($urandom() & ~32'h1F) | 32'(hr));
      set_reg(CfgMinuteOfHour, ($urandom() & ~32'h3F) | 32'(mn));
      set_reg(CfgInBattle, ($urandom() & ~32'h1) | 32'(bat));
      set_reg(CfgMapExempt, ($urandom() & ~32'h1) | 32'(exm));
      set_reg(CfgFadeActive, ($urandom() & ~32'h1) | 32'(fad));
      set_reg(CfgWorldPaletteMask, wm);
      set_reg(CfgBattlePaletteMask, bm);
      set_reg(CfgUnused, $urandom());
      @(negedge clk_i);
      for (int i = 0; i < 54; i++) pending.push_back(random_item());
      drain();
    end

    $display("summary: %0d palette entries over %0d time-of-day settings, %0d results",
             n_items, Phases + 1, n_results);
    $display("summary: %0d light rewrites reported, %0d mismatches", n_rewrites, n_fail);
    if (n_fail == 0 && tint_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
